// File: rtl/kf3_pkg.sv
// Shared types and constants for the 3x3 kernel filter.
package kf3_pkg;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 16;
    localparam int SUM_W  = 13;   // signed kernel sum, covers -2040..4080
    localparam int MULT_W = 25;   // reciprocal constant width

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Register reset values
    localparam logic [COL_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [ROW_W-1:0] HEIGHT_RST = 16'd1024;

    // Box: floor(S*11111/100000) as (S*BOX_MULT) >> BOX_SHIFT, exact for S < 4096
    localparam int BOX_SHIFT = 28;
    localparam logic [63:0] BOX_NUM = 64'd11111 << BOX_SHIFT;
    localparam logic [MULT_W-1:0] BOX_MULT = MULT_W'((BOX_NUM + 64'd99999) / 64'd100000);

    // Divide by 3 as (m*DIV3_MULT) >> DIV3_SHIFT, exact for m < 1024
    localparam int DIV3_SHIFT = 11;
    localparam logic [MULT_W-1:0] DIV3_MULT =
        MULT_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

    typedef logic [PIX_W-1:0] pix_t;

    // Window, index row*3+col, row 0 oldest line, col 0 oldest column
    typedef pix_t [8:0] win_t;

    typedef enum logic [2:0] {
        KIND_BOX       = 3'd0,
        KIND_GAUSS     = 3'd1,
        KIND_PREWITT_X = 3'd2,
        KIND_PREWITT_Y = 3'd3,
        KIND_SOBEL_X   = 3'd4,
        KIND_SOBEL_Y   = 3'd5,
        KIND_LAPLACE   = 3'd6,
        KIND_SHARPEN   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        REG_KIND   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        kind_t             kind;
        logic [COL_W-1:0]  width;
        logic [ROW_W-1:0]  height;
    } cfg_t;

    typedef struct packed {
        win_t  win;
        logic  frame_end;
    } q_entry_t;

endpackage

// File: rtl/kf3_front.sv
// Front end: raster counters, line stores, window and result classification.
module kf3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  kf3_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  kf3_pkg::pix_t               in_pixel,
    input  logic [kf3_pkg::QCNT_W-1:0]  q_count,
    output logic                        push_valid,
    output kf3_pkg::q_entry_t           push_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [kf3_pkg::COL_W-1:0] col_reg, col_next;
    logic [kf3_pkg::ROW_W-1:0] row_reg, row_next;
    logic [kf3_pkg::COL_W-1:0] eff_w;
    logic [kf3_pkg::ROW_W-1:0] eff_h;
    logic [kf3_pkg::COL_W:0]   col_inc;
    logic [kf3_pkg::ROW_W:0]   row_adv;
    logic [AW-1:0]             rd_idx;
    logic                      accept;
    logic                      prod, fe;

    logic                      a_valid_reg;
    kf3_pkg::pix_t             a_px_reg;
    logic [AW-1:0]             a_idx_reg;
    logic                      a_prod_reg;
    logic                      a_fe_reg;
    kf3_pkg::pix_t             top_rd_reg, mid_rd_reg;
    kf3_pkg::win_t             win_reg, win_next;

    kf3_pkg::pix_t upper_line_mem  [MAX_WIDTH];
    kf3_pkg::pix_t middle_line_mem [MAX_WIDTH];

    // Room for the word in flight plus one more
    assign in_ready = (q_count + kf3_pkg::QCNT_W'(a_valid_reg))
                      < kf3_pkg::QCNT_W'(kf3_pkg::QDEPTH);
    assign accept   = in_valid && in_ready;

    // Effective frame size
    always_comb begin
        if (cfg.width < kf3_pkg::COL_W'(3)) begin
            eff_w = kf3_pkg::COL_W'(3);
        end else if (int'(cfg.width) > MAX_WIDTH) begin
            eff_w = kf3_pkg::COL_W'(MAX_WIDTH);
        end else begin
            eff_w = cfg.width;
        end
        eff_h = (cfg.height < kf3_pkg::ROW_W'(3)) ? kf3_pkg::ROW_W'(3) : cfg.height;
    end

    // Line store address, clamped to the store depth
    always_comb begin
        if (int'(col_reg) < MAX_WIDTH) begin
            rd_idx = AW'(col_reg);
        end else begin
            rd_idx = AW'(MAX_WIDTH - 1);
        end
    end

    // Counter advance and classification
    always_comb begin
        col_inc = {1'b0, col_reg} + 1'b1;
        if (col_inc >= {1'b0, eff_w}) begin
            col_next = '0;
            row_adv  = {1'b0, row_reg} + 1'b1;
        end else begin
            col_next = col_inc[kf3_pkg::COL_W-1:0];
            row_adv  = {1'b0, row_reg};
        end
        if (row_adv >= {1'b0, eff_h}) begin
            row_next = '0;
        end else begin
            row_next = row_adv[kf3_pkg::ROW_W-1:0];
        end
        prod = (row_reg >= kf3_pkg::ROW_W'(2)) && (col_reg >= kf3_pkg::COL_W'(2));
        fe   = (row_reg == eff_h - 1'b1) && (col_reg == eff_w - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            win_reg     <= '0;
        end else begin
            a_valid_reg <= accept;
            win_reg     <= win_next;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Stage A payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_px_reg   <= in_pixel;
            a_idx_reg  <= rd_idx;
            a_prod_reg <= prod;
            a_fe_reg   <= fe;
        end
    end

    // Line stores: read on accept, write back in the following cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            top_rd_reg <= upper_line_mem[rd_idx];
            mid_rd_reg <= middle_line_mem[rd_idx];
        end
        if (a_valid_reg) begin
            upper_line_mem[a_idx_reg]  <= mid_rd_reg;
            middle_line_mem[a_idx_reg] <= a_px_reg;
        end
    end

    // Window shift, new column on the right
    always_comb begin
        win_next = win_reg;
        if (a_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r*3]   = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
            win_next[2] = top_rd_reg;
            win_next[5] = mid_rd_reg;
            win_next[8] = a_px_reg;
        end
    end

    assign push_valid          = a_valid_reg && a_prod_reg;
    assign push_data.win       = win_next;
    assign push_data.frame_end = a_fe_reg;

endmodule

// File: rtl/kf3_queue.sv
// Short window queue between front end and filter back end.
module kf3_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  kf3_pkg::q_entry_t           push_data,
    input  logic                        pop,
    output kf3_pkg::q_entry_t           head,
    output logic [kf3_pkg::QCNT_W-1:0]  count
);

    kf3_pkg::q_entry_t              entry_reg [kf3_pkg::QDEPTH];
    logic [kf3_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [kf3_pkg::QCNT_W-1:0]     count_reg, count_next;

    // Occupancy
    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: rtl/kf3_back.sv
// Back end: kernel sum, scaling and output register.
module kf3_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  kf3_pkg::kind_t              kind,
    input  kf3_pkg::q_entry_t           head,
    input  logic [kf3_pkg::QCNT_W-1:0]  q_count,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output kf3_pkg::pix_t               out_data,
    output logic                        out_last
);

    localparam int PROD_W = kf3_pkg::SUM_W + kf3_pkg::MULT_W;

    logic signed [kf3_pkg::SUM_W-1:0] p [9];
    logic signed [kf3_pkg::SUM_W-1:0] sum;
    logic signed [kf3_pkg::SUM_W-1:0] edge_sum;

    logic                             v1_reg;
    logic signed [kf3_pkg::SUM_W-1:0] s1_reg;
    kf3_pkg::kind_t                   k1_reg;
    logic                             fe1_reg;

    logic [kf3_pkg::SUM_W-1:0]        mag;
    logic [kf3_pkg::MULT_W-1:0]       mul_k;
    logic [PROD_W-1:0]                prod;
    logic [PROD_W-1:0]                box_q, div3_q;
    kf3_pkg::pix_t                    res;

    logic                             out_valid_reg;
    kf3_pkg::pix_t                    out_data_reg;
    logic                             out_last_reg;

    logic en_out, b1_load;

    // Stage flow: each stage loads when it is empty or when the stage after it moves on
    assign en_out  = !out_valid_reg || out_ready;
    assign b1_load = !v1_reg || en_out;
    assign pop     = (q_count != '0) && b1_load;

    // Window taps as signed values
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            p[i] = $signed({{(kf3_pkg::SUM_W-kf3_pkg::PIX_W){1'b0}}, head.win[i]});
        end
    end

    // Kernel sum for the selected filter
    always_comb begin
        edge_sum = p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8];
        case (kind)
            kf3_pkg::KIND_BOX:       sum = edge_sum + p[4];
            kf3_pkg::KIND_GAUSS:     sum = p[0] + (p[1] <<< 1) + p[2] + (p[3] <<< 1)
                                         + (p[4] <<< 2) + (p[5] <<< 1) + p[6]
                                         + (p[7] <<< 1) + p[8];
            kf3_pkg::KIND_PREWITT_X: sum = p[2] + p[5] + p[8] - p[0] - p[3] - p[6];
            kf3_pkg::KIND_PREWITT_Y: sum = p[6] + p[7] + p[8] - p[0] - p[1] - p[2];
            kf3_pkg::KIND_SOBEL_X:   sum = p[2] + (p[5] <<< 1) + p[8]
                                         - p[0] - (p[3] <<< 1) - p[6];
            kf3_pkg::KIND_SOBEL_Y:   sum = p[6] + (p[7] <<< 1) + p[8]
                                         - p[0] - (p[1] <<< 1) - p[2];
            kf3_pkg::KIND_LAPLACE:   sum = (p[4] <<< 3) - edge_sum;
            kf3_pkg::KIND_SHARPEN:   sum = (p[4] <<< 3) + p[4] - edge_sum;
            default:                 sum = edge_sum + p[4];
        endcase
    end

    // Scaling: one shared reciprocal multiply, shifts and clamp
    always_comb begin
        mag    = (s1_reg < 0) ? kf3_pkg::SUM_W'(-s1_reg) : kf3_pkg::SUM_W'(s1_reg);
        mul_k  = (k1_reg == kf3_pkg::KIND_BOX) ? kf3_pkg::BOX_MULT : kf3_pkg::DIV3_MULT;
        prod   = PROD_W'(mag) * PROD_W'(mul_k);
        box_q  = prod >> kf3_pkg::BOX_SHIFT;
        div3_q = prod >> kf3_pkg::DIV3_SHIFT;
        case (k1_reg)
            kf3_pkg::KIND_BOX:       res = box_q[kf3_pkg::PIX_W-1:0];
            kf3_pkg::KIND_GAUSS:     res = mag[kf3_pkg::PIX_W+3:4];
            kf3_pkg::KIND_PREWITT_X,
            kf3_pkg::KIND_PREWITT_Y: res = div3_q[kf3_pkg::PIX_W-1:0];
            kf3_pkg::KIND_SOBEL_X,
            kf3_pkg::KIND_SOBEL_Y:   res = mag[kf3_pkg::PIX_W+1:2];
            kf3_pkg::KIND_LAPLACE:   res = mag[kf3_pkg::PIX_W+2:3];
            kf3_pkg::KIND_SHARPEN: begin
                if (s1_reg < 0) begin
                    res = '0;
                end else if (s1_reg > kf3_pkg::SUM_W'(255)) begin
                    res = '1;
                end else begin
                    res = s1_reg[kf3_pkg::PIX_W-1:0];
                end
            end
            default:                 res = box_q[kf3_pkg::PIX_W-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (b1_load) begin
                v1_reg <= pop;
            end
            if (en_out) begin
                out_valid_reg <= v1_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_reg  <= sum;
            k1_reg  <= kind;
            fe1_reg <= head.frame_end;
        end
        if (en_out && v1_reg) begin
            out_data_reg <= res;
            out_last_reg <= fe1_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/kernel_filter_3x3_unit.sv
// Throughput: one pixel per cycle while the queue has room; a result stall can fill it.
// Line stores: one read, one write per cycle. Path: stage A, queue, stage 1, output reg.
// Border pixels give no result word; the last interior result of a frame has tlast set.
// Reset (aresetn low, synchronous) clears counters, window, queue and pipeline valids;
// registers return to box filter, 1024 x 1024. Line stores are not cleared.
module kernel_filter_3x3_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    // filtered stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] filtered
    output logic        m_tlast,   // frame_end
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    kf3_pkg::kind_t                  kind_reg;
    logic [kf3_pkg::COL_W-1:0]       width_reg;
    logic [kf3_pkg::ROW_W-1:0]       height_reg;
    kf3_pkg::cfg_t                   cfg;
    logic                            wr;
    kf3_pkg::reg_idx_t               reg_idx;

    logic                            push_valid;
    kf3_pkg::q_entry_t               push_data;
    kf3_pkg::q_entry_t               head;
    logic [kf3_pkg::QCNT_W-1:0]      q_count;
    logic                            pop;

    // Register port
    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign reg_idx = kf3_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= kf3_pkg::KIND_BOX;
            width_reg  <= kf3_pkg::WIDTH_RST;
            height_reg <= kf3_pkg::HEIGHT_RST;
        end else if (wr) begin
            case (reg_idx)
                kf3_pkg::REG_KIND:   kind_reg   <= kf3_pkg::kind_t'(pwdata[2:0]);
                kf3_pkg::REG_WIDTH:  width_reg  <= pwdata[kf3_pkg::COL_W-1:0];
                kf3_pkg::REG_HEIGHT: height_reg <= pwdata[kf3_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            kf3_pkg::REG_KIND:   prdata = {29'd0, kind_reg};
            kf3_pkg::REG_WIDTH:  prdata = {21'd0, width_reg};
            kf3_pkg::REG_HEIGHT: prdata = {16'd0, height_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.kind   = kind_reg;
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

    kf3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pixel   (s_tdata),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    kf3_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .count     (q_count)
    );

    kf3_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kind      (kind_reg),
        .head      (head),
        .q_count   (q_count),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: rtl/kf3_checker.sv
// Port-level checks for the 3x3 kernel filter, bound to the top level.
module kf3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    logic wr;
    assign wr = psel && penable && pwrite && pready;

    // Stalled result word stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result word dropped while stalled");

    // Stalled result word keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("result payload changed while stalled");

    // No result word right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // Input side is ready right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // Filter kind reads back what was written
    a_kind_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && (paddr[3:2] == kf3_pkg::REG_KIND)) |=>
        ((paddr[3:2] != kf3_pkg::REG_KIND) || (prdata[2:0] == $past(pwdata[2:0]))))
        else $error("filter kind readback mismatch");

endmodule

bind kernel_filter_3x3_unit kf3_checker u_kf3_checker (.*);

// File: tb/sv/kernel_filter_3x3_unit_tb.sv
// Self-checking bench for kernel_filter_3x3_unit: register setup, pixel words in, results checked.
module kernel_filter_3x3_unit_tb;

    localparam int MAX_W         = 1024;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int DRAIN_CYCLES  = 8;     // settle time after the last expected word
    localparam int QUIET_LIMIT   = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [3:0] UNUSED_ADDR = 4'd12;   // no register behind this address

    typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_NARROW} px_mix_t;

    typedef struct packed {
        kf3_pkg::pix_t filtered;
        logic          frame_end;
    } filt_word_t;

    typedef struct packed {
        kf3_pkg::kind_t kind;
        logic [23:0]    pixels;      // column 0 in the low byte
        logic           pinned;      // expected word typed in below
        kf3_pkg::pix_t  pinned_val;
        logic           pinned_last;
    } pixel_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] pixel
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [7:0] filtered
    logic        m_tlast;     // frame_end
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Software copy of the filter state
    kf3_pkg::kind_t            cur_kind;
    logic [kf3_pkg::COL_W-1:0] cur_width_reg;
    logic [kf3_pkg::ROW_W-1:0] cur_height_reg;
    kf3_pkg::pix_t             upper_row [MAX_W];
    kf3_pkg::pix_t             middle_row [MAX_W];
    bit                        upper_known [MAX_W];
    bit                        middle_known [MAX_W];
    kf3_pkg::win_t             win;
    int unsigned               col_pos;
    int unsigned               row_pos;

    filt_word_t pending_results [$];
    pixel_row_t directed_rows [10];
    int         mismatches;
    int         quiet_cycles;
    bit         send_gaps_on;
    bit         stall_on;

    kernel_filter_3x3_unit #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL kernel_filter_3x3_unit");
            $finish;
        end
    end

    function automatic int unsigned clamp_width(logic [kf3_pkg::COL_W-1:0] w);
        if (w < 3) return 3;
        if (w > MAX_W) return MAX_W;
        return w;
    endfunction

    function automatic int unsigned clamp_height(logic [kf3_pkg::ROW_W-1:0] h);
        return (h < 3) ? 3 : h;
    endfunction

    // Weighted 3x3 sum and the per-kind scaling
    function automatic kf3_pkg::pix_t filter_window(kf3_pkg::kind_t kind, kf3_pkg::win_t w);
        int tap [9];
        int acc;
        int mag;
        case (kind)
            kf3_pkg::KIND_BOX:       tap = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
            kf3_pkg::KIND_GAUSS:     tap = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
            kf3_pkg::KIND_PREWITT_X: tap = '{-1, 0, 1, -1, 0, 1, -1, 0, 1};
            kf3_pkg::KIND_PREWITT_Y: tap = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
            kf3_pkg::KIND_SOBEL_X:   tap = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
            kf3_pkg::KIND_SOBEL_Y:   tap = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
            kf3_pkg::KIND_LAPLACE:   tap = '{-1, -1, -1, -1, 8, -1, -1, -1, -1};
            default:                 tap = '{-1, -1, -1, -1, 9, -1, -1, -1, -1};
        endcase
        acc = 0;
        for (int i = 0; i < 9; i++) acc += tap[i] * int'(w[i]);
        mag = (acc < 0) ? -acc : acc;
        case (kind)
            kf3_pkg::KIND_BOX:       return kf3_pkg::pix_t'(acc * 11111 / 100000);
            kf3_pkg::KIND_GAUSS:     return kf3_pkg::pix_t'(acc / 16);
            kf3_pkg::KIND_PREWITT_X,
            kf3_pkg::KIND_PREWITT_Y: return kf3_pkg::pix_t'(mag / 3);
            kf3_pkg::KIND_SOBEL_X,
            kf3_pkg::KIND_SOBEL_Y:   return kf3_pkg::pix_t'(mag / 4);
            kf3_pkg::KIND_LAPLACE:   return kf3_pkg::pix_t'(mag / 8);
            default: begin
                if (acc < 0) return 8'd0;
                if (acc > 255) return 8'd255;
                return kf3_pkg::pix_t'(acc);
            end
        endcase
    endfunction

    // Shift one pixel into the line stores and window, advance raster position
    task automatic shift_in_pixel(input kf3_pkg::pix_t px, output bit produced,
                                  output filt_word_t word);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        w = clamp_width(cur_width_reg);
        h = clamp_height(cur_height_reg);
        idx = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
        for (int r = 0; r < 3; r++) begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = upper_row[idx];
        win[5] = middle_row[idx];
        win[8] = px;
        upper_row[idx]    = middle_row[idx];
        upper_known[idx]  = middle_known[idx];
        middle_row[idx]   = px;
        middle_known[idx] = 1'b1;
        produced = (row_pos >= 2) && (col_pos >= 2);
        word.filtered  = filter_window(cur_kind, win);
        word.frame_end = (row_pos == h - 1) && (col_pos == w - 1);
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
    endtask

    // A width change must never lead to a filtered word built from unwritten store entries
    function automatic bit width_change_safe(int unsigned new_w);
        int unsigned idx;
        if (col_pos == 0 && row_pos == 0) return 1'b1;
        idx = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
        if (!(upper_known[idx] && middle_known[idx])) return 1'b0;
        for (int i = 0; i < new_w; i++) begin
            if (!(upper_known[i] && middle_known[i])) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    function automatic logic [3:0] reg_addr(kf3_pkg::reg_idx_t idx);
        return {idx, 2'b00};
    endfunction

    // APB write: setup cycle, access cycle, then bus idle
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input kf3_pkg::reg_idx_t idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) flag_mismatch($sformatf("register %s", idx.name()), want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write all three registers (junk above each field), track them, read them back
    task automatic set_config(input kf3_pkg::kind_t k, input logic [kf3_pkg::COL_W-1:0] w,
                              input logic [kf3_pkg::ROW_W-1:0] h);
        logic [31:0] junk;
        junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
        reg_write(reg_addr(kf3_pkg::REG_KIND), {junk[31:3], k});
        reg_write(reg_addr(kf3_pkg::REG_WIDTH), {junk[31:kf3_pkg::COL_W], w});
        reg_write(reg_addr(kf3_pkg::REG_HEIGHT), {junk[31:kf3_pkg::ROW_W], h});
        cur_kind       = k;
        cur_width_reg  = w;
        cur_height_reg = h;
        check_reg(kf3_pkg::REG_KIND, 32'(k));
        check_reg(kf3_pkg::REG_WIDTH, 32'(w));
        check_reg(kf3_pkg::REG_HEIGHT, 32'(h));
    endtask

    // Offer one pixel word; on acceptance queue its filtered word, if any
    task automatic send_pixel(input kf3_pkg::pix_t px, input bit pin, input filt_word_t pinned);
        int         gap;
        bit         produced;
        filt_word_t word;
        gap = send_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        shift_in_pixel(px, produced, word);
        if (produced) pending_results.push_back(pin ? pinned : word);
    endtask

    // Stop sending and let every queued word drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic kf3_pkg::pix_t draw_pixel(px_mix_t mix);
        case (mix)
            MIX_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            MIX_NARROW:  return kf3_pkg::pix_t'($urandom_range(100, 140));
            default:     return kf3_pkg::pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side: random stall before each word if stall_on, compare against oldest expectation
    initial begin : result_sink
        int         stall;
        filt_word_t want;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = stall_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_results.size() == 0) begin
                flag_mismatch("word with nothing pending", 0, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.filtered) flag_mismatch("filtered", want.filtered, m_tdata);
                if (m_tlast !== want.frame_end) flag_mismatch("frame_end", want.frame_end, m_tlast);
            end
        end
    end

    initial begin : stimulus
        int                        phase;
        int                        n;
        int                        random_sent;
        int unsigned               w;
        int unsigned               h;
        int unsigned               to_end;
        logic [kf3_pkg::COL_W-1:0] nw;
        logic [kf3_pkg::ROW_W-1:0] nh;
        kf3_pkg::kind_t            nk;
        px_mix_t                   mix;
        filt_word_t                pinned;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        mismatches   = 0;
        send_gaps_on = 1'b1;
        stall_on     = 1'b1;

        cur_kind       = kf3_pkg::KIND_BOX;
        cur_width_reg  = kf3_pkg::WIDTH_RST;
        cur_height_reg = kf3_pkg::HEIGHT_RST;
        win     = '0;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < MAX_W; i++) begin
            upper_row[i]    = '0;
            middle_row[i]   = '0;
            upper_known[i]  = 1'b0;
            middle_known[i] = 1'b0;
        end

        // One 3-wide, 10-high frame: two all-white rows, then one result row per kind
        directed_rows = '{
            '{kf3_pkg::KIND_BOX,       24'hFFFFFF, 1'b0, 8'd0,   1'b0},
            '{kf3_pkg::KIND_BOX,       24'hFFFFFF, 1'b0, 8'd0,   1'b0},
            '{kf3_pkg::KIND_BOX,       24'hFFFFFF, 1'b1, 8'd254, 1'b0},  // flat white box
            '{kf3_pkg::KIND_GAUSS,     24'h000000, 1'b0, 8'd0,   1'b0},
            '{kf3_pkg::KIND_PREWITT_X, 24'hFF8000, 1'b0, 8'd0,   1'b0},
            '{kf3_pkg::KIND_PREWITT_Y, 24'hFF00FF, 1'b0, 8'd0,   1'b0},
            '{kf3_pkg::KIND_SOBEL_X,   24'h0000FF, 1'b0, 8'd0,   1'b0},
            '{kf3_pkg::KIND_SOBEL_Y,   24'h00FF00, 1'b0, 8'd0,   1'b0},
            '{kf3_pkg::KIND_LAPLACE,   24'hFFFFFF, 1'b0, 8'd0,   1'b0},
            '{kf3_pkg::KIND_SHARPEN,   24'h000000, 1'b0, 8'd0,   1'b0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A write to the unused address must leave the reset values in place
        reg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
        check_reg(kf3_pkg::REG_KIND, 32'(kf3_pkg::KIND_BOX));
        check_reg(kf3_pkg::REG_WIDTH, 32'(kf3_pkg::WIDTH_RST));
        check_reg(kf3_pkg::REG_HEIGHT, 32'(kf3_pkg::HEIGHT_RST));

        // Directed frame
        set_config(kf3_pkg::KIND_BOX, 11'd3, 16'd10);
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind != cur_kind) begin
                wait_idle();
                set_config(directed_rows[i].kind, cur_width_reg, cur_height_reg);
            end
            pinned.filtered  = directed_rows[i].pinned_val;
            pinned.frame_end = directed_rows[i].pinned_last;
            for (int c = 0; c < 3; c++) begin
                send_pixel(directed_rows[i].pixels[c*8 +: 8], directed_rows[i].pinned, pinned);
            end
        end
        wait_idle();

        // Random phases: mostly whole frames, some cut short mid-frame
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            send_gaps_on = ($urandom_range(0, 3) != 0);
            stall_on     = ($urandom_range(0, 3) != 0);
            mix          = px_mix_t'($urandom_range(0, 2));
            nk           = kf3_pkg::kind_t'($urandom_range(0, 7));
            case ($urandom_range(0, 19))
                0, 1:    nw = kf3_pkg::COL_W'($urandom_range(0, 2));
                2:       nw = kf3_pkg::COL_W'($urandom_range(MAX_W, 2047));
                default: nw = kf3_pkg::COL_W'($urandom_range(3, 12));
            endcase
            case ($urandom_range(0, 9))
                0:       nh = kf3_pkg::ROW_W'($urandom_range(0, 2));
                1:       nh = '1;
                2:       nh = kf3_pkg::ROW_W'($urandom_range(9, 40));
                default: nh = kf3_pkg::ROW_W'($urandom_range(3, 8));
            endcase
            if (phase == 0) begin
                nw = '0;
                nh = '1;
            end
            if (!width_change_safe(clamp_width(nw))) nw = cur_width_reg;
            set_config(nk, nw, nh);

            w = clamp_width(cur_width_reg);
            h = clamp_height(cur_height_reg);
            to_end = (col_pos < w && row_pos < h) ? (h - 1 - row_pos) * w + (w - col_pos) : 0;
            if ($urandom_range(0, 2) != 0 && to_end != 0 && to_end <= 240) begin
                n = to_end;
            end else begin
                n = $urandom_range(1, 60);
            end
            for (int i = 0; i < n; i++) send_pixel(draw_pixel(mix), 1'b0, pinned);
            random_sent += n;
            phase++;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("PASS kernel_filter_3x3_unit");
        end else begin
            $display("FAIL kernel_filter_3x3_unit");
        end
        $finish;
    end

endmodule
